/* sv/trigger_timestamp_realigner_macros.svh */
// assertion helpers for the checker in ttr_checker.sv
`ifndef TRIGGER_TIMESTAMP_REALIGNER_MACROS_SVH
`define TRIGGER_TIMESTAMP_REALIGNER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define TTR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttr assertion failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define TTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttr assertion failed");

`endif

/* sv/ttr_pkg.sv */
`default_nettype none

package ttr_pkg;

  localparam int unsigned StampW      = 63;
  localparam int unsigned CfgW        = 40;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned AluW        = 64;
  localparam int unsigned DefRingDepth = 16;

  typedef logic [StampW-1:0]  stamp_t;
  typedef logic [CfgW-1:0]    cfg_word_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [AluW-1:0]    alu_word_t;

  // configuration register indexes
  localparam cfg_idx_t CfgMatchTol = 1'b0;
  localparam cfg_idx_t CfgMaxWait  = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StSub,
    StAbs,
    StCmp
  } state_e;

endpackage

`default_nettype wire

/* sv/ttr_in_if.sv */
`default_nettype none

interface ttr_in_if;
  logic           valid;
  logic           ready;
  logic           kind;
  ttr_pkg::stamp_t event_precise_stamp;
  ttr_pkg::stamp_t event_utc_stamp;
  ttr_pkg::stamp_t trigger_stamp;
  ttr_pkg::stamp_t now_ns;

  modport source (
    output valid, kind, event_precise_stamp, event_utc_stamp, trigger_stamp, now_ns,
    input  ready
  );
  modport sink (
    input  valid, kind, event_precise_stamp, event_utc_stamp, trigger_stamp, now_ns,
    output ready
  );
  modport monitor (
    input valid, ready, kind, event_precise_stamp, event_utc_stamp, trigger_stamp, now_ns
  );
endinterface

`default_nettype wire

/* sv/ttr_out_if.sv */
`default_nettype none

interface ttr_out_if;
  logic           valid;
  logic           ready;
  logic           released;
  logic           no_match_flag;
  ttr_pkg::stamp_t stamp_out;
  logic           overflow;

  modport source (
    output valid, released, no_match_flag, stamp_out, overflow,
    input  ready
  );
  modport sink (
    input  valid, released, no_match_flag, stamp_out, overflow,
    output ready
  );
  modport monitor (
    input valid, ready, released, no_match_flag, stamp_out, overflow
  );
endinterface

`default_nettype wire

/* sv/trigger_timestamp_realigner.sv */
// Realigns trigger stamps to precise timing events held in a ring of RING_DEPTH entries.
// An add beat (kind 0) stores one event and returns its result in the cycle after the
// accept, with overflow set when the oldest event had to be dropped. A trigger beat
// (kind 1) walks the ring from the oldest event; every event out of tolerance is
// dropped and sets no_match_flag, the first event within tolerance is consumed and its
// precise stamp is released; if none is, the trigger's own stamp is released. A trigger
// that finds the ring empty is held (released 0) and should be presented again; it is
// forced out with no_match_flag once the time since the first hold exceeds max_wait_ns.
// Exactly one result beat per input beat. All arithmetic goes through one 64-bit
// subtractor, so each comparison is three steps: a difference (StSub), an absolute
// value (StAbs) and a limit check (StCmp). A trigger on an empty ring goes straight to
// StSub; each event that a walk examines first passes StRead for the registered ring
// read. The block accepts one beat at a time and is not ready while a trigger is being
// processed. Config writes are only to be issued while the block is idle.
`default_nettype none

module trigger_timestamp_realigner #(
  parameter int unsigned RING_DEPTH = ttr_pkg::DefRingDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire ttr_pkg::cfg_idx_t  cfg_idx_i,
  input  wire ttr_pkg::cfg_word_t cfg_data_i,
  ttr_in_if.sink                  in_i,
  ttr_out_if.source               out_o
);

  localparam int unsigned PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned OccW = $clog2(RING_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPos = PtrW'(RING_DEPTH - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(RING_DEPTH);
  localparam logic [OccW-1:0] OneOcc  = OccW'(1);

  // ring storage, no reset: an entry is only read while occupied
  ttr_pkg::stamp_t precise_mem [RING_DEPTH];
  ttr_pkg::stamp_t utc_mem     [RING_DEPTH];

  // control state
  ttr_pkg::state_e   state_q, state_d;
  ttr_pkg::cfg_word_t tol_q, wait_lim_q;
  logic [PtrW-1:0]   wr_pos_q, wr_pos_d;
  logic [PtrW-1:0]   rd_pos_q, rd_pos_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic              waiting_q, waiting_d;
  ttr_pkg::stamp_t   wait_start_q, wait_start_d;
  logic              walk_q, walk_d;     // 1: walking the ring, 0: checking a hold
  logic              flag_q, flag_d;     // an event was dropped during this walk
  logic              out_valid_q, out_valid_d;

  // payload state
  ttr_pkg::stamp_t   trig_q, trig_d;
  ttr_pkg::stamp_t   now_q, now_d;
  ttr_pkg::stamp_t   rd_precise_q, rd_utc_q;
  ttr_pkg::alu_word_t res_q, res_d;
  logic              borrow_q, borrow_d;
  logic              out_released_q, out_released_d;
  logic              out_flag_q, out_flag_d;
  ttr_pkg::stamp_t   out_stamp_q, out_stamp_d;
  logic              out_ovf_q, out_ovf_d;

  logic              in_ready;
  logic              in_acc;
  logic              mem_we;

  // shared subtractor
  ttr_pkg::alu_word_t alu_a, alu_b;
  logic [ttr_pkg::AluW:0] alu_res;
  logic              alu_borrow;
  ttr_pkg::cfg_word_t lim;

  assign in_ready = (state_q == ttr_pkg::StIdle) && (!out_valid_q || out_o.ready);
  assign in_acc   = in_i.valid && in_ready;
  assign mem_we   = in_acc && !in_i.kind;

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.released      = out_released_q;
  assign out_o.no_match_flag = out_flag_q;
  assign out_o.stamp_out     = out_stamp_q;
  assign out_o.overflow      = out_ovf_q;

  function automatic logic [PtrW-1:0] next_pos(input logic [PtrW-1:0] p);
    return (p == LastPos) ? '0 : p + PtrW'(1);
  endfunction

  // operand select for the subtractor
  assign lim = walk_q ? tol_q : wait_lim_q;

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      ttr_pkg::StSub: begin
        // signed difference of the two stamps
        alu_a = walk_q ? {1'b0, trig_q}   : {1'b0, now_q};
        alu_b = walk_q ? {1'b0, rd_utc_q} : {1'b0, wait_start_q};
      end
      ttr_pkg::StAbs: begin
        // negate, kept only when the difference went negative
        alu_a = '0;
        alu_b = res_q;
      end
      ttr_pkg::StCmp: begin
        // borrow out means the distance exceeds the limit
        alu_a = {{(ttr_pkg::AluW - ttr_pkg::CfgW){1'b0}}, lim};
        alu_b = res_q;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_res    = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_res[ttr_pkg::AluW];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttr_pkg::StIdle: begin
        if (in_acc && in_i.kind) begin
          state_d = (occ_q == '0) ? ttr_pkg::StSub : ttr_pkg::StRead;
        end
      end
      ttr_pkg::StRead: state_d = ttr_pkg::StSub;
      ttr_pkg::StSub:  state_d = ttr_pkg::StAbs;
      ttr_pkg::StAbs:  state_d = ttr_pkg::StCmp;
      ttr_pkg::StCmp: begin
        // keep walking while events are dropped and some remain
        if (walk_q && alu_borrow && (occ_q != OneOcc)) begin
          state_d = ttr_pkg::StRead;
        end else begin
          state_d = ttr_pkg::StIdle;
        end
      end
      default: state_d = ttr_pkg::StIdle;
    endcase
  end

  // datapath and result
  always_comb begin
    wr_pos_d       = wr_pos_q;
    rd_pos_d       = rd_pos_q;
    occ_d          = occ_q;
    waiting_d      = waiting_q;
    wait_start_d   = wait_start_q;
    walk_d         = walk_q;
    flag_d         = flag_q;
    trig_d         = trig_q;
    now_d          = now_q;
    res_d          = res_q;
    borrow_d       = borrow_q;
    out_valid_d    = out_valid_q;
    out_released_d = out_released_q;
    out_flag_d     = out_flag_q;
    out_stamp_d    = out_stamp_q;
    out_ovf_d      = out_ovf_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ttr_pkg::StIdle: begin
        if (in_acc) begin
          trig_d = in_i.trigger_stamp;
          now_d  = in_i.now_ns;
          if (!in_i.kind) begin
            wr_pos_d       = next_pos(wr_pos_q);
            out_valid_d    = 1'b1;
            out_released_d = 1'b0;
            out_flag_d     = 1'b0;
            out_stamp_d    = '0;
            if (occ_q == FullOcc) begin
              // full ring: drop the oldest event
              rd_pos_d  = next_pos(rd_pos_q);
              out_ovf_d = 1'b1;
            end else begin
              occ_d     = occ_q + OccW'(1);
              out_ovf_d = 1'b0;
            end
          end else begin
            walk_d = (occ_q != '0);
            flag_d = 1'b0;
            if ((occ_q == '0) && !waiting_q) begin
              // first hold starts the wait clock
              waiting_d    = 1'b1;
              wait_start_d = in_i.now_ns;
            end
          end
        end
      end
      ttr_pkg::StRead: begin
      end
      ttr_pkg::StSub: begin
        res_d    = alu_res[ttr_pkg::AluW-1:0];
        borrow_d = alu_borrow;
      end
      ttr_pkg::StAbs: begin
        if (borrow_q) begin
          res_d = alu_res[ttr_pkg::AluW-1:0];
        end
      end
      ttr_pkg::StCmp: begin
        out_ovf_d = 1'b0;
        if (walk_q) begin
          // event consumed either way
          rd_pos_d     = next_pos(rd_pos_q);
          occ_d        = occ_q - OccW'(1);
          waiting_d    = 1'b0;
          wait_start_d = '0;
          if (alu_borrow) begin
            flag_d = 1'b1;
            if (occ_q == OneOcc) begin
              // ring ran dry: release the trigger's own stamp
              out_valid_d    = 1'b1;
              out_released_d = 1'b1;
              out_flag_d     = 1'b1;
              out_stamp_d    = trig_q;
            end
          end else begin
            out_valid_d    = 1'b1;
            out_released_d = 1'b1;
            out_flag_d     = flag_q;
            out_stamp_d    = rd_precise_q;
          end
        end else begin
          out_valid_d = 1'b1;
          if (alu_borrow) begin
            // wait timed out
            waiting_d      = 1'b0;
            wait_start_d   = '0;
            out_released_d = 1'b1;
            out_flag_d     = 1'b1;
            out_stamp_d    = trig_q;
          end else begin
            out_released_d = 1'b0;
            out_flag_d     = 1'b0;
            out_stamp_d    = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ttr_pkg::StIdle;
      tol_q        <= '0;
      wait_lim_q   <= '0;
      wr_pos_q     <= '0;
      rd_pos_q     <= '0;
      occ_q        <= '0;
      waiting_q    <= 1'b0;
      wait_start_q <= '0;
      walk_q       <= 1'b0;
      flag_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wr_pos_q     <= wr_pos_d;
      rd_pos_q     <= rd_pos_d;
      occ_q        <= occ_d;
      waiting_q    <= waiting_d;
      wait_start_q <= wait_start_d;
      walk_q       <= walk_d;
      flag_q       <= flag_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ttr_pkg::CfgMatchTol: tol_q      <= cfg_data_i;
          ttr_pkg::CfgMaxWait:  wait_lim_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q         <= trig_d;
    now_q          <= now_d;
    res_q          <= res_d;
    borrow_q       <= borrow_d;
    out_released_q <= out_released_d;
    out_flag_q     <= out_flag_d;
    out_stamp_q    <= out_stamp_d;
    out_ovf_q      <= out_ovf_d;
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      precise_mem[wr_pos_q] <= in_i.event_precise_stamp;
      utc_mem[wr_pos_q]     <= in_i.event_utc_stamp;
    end
    if (state_q == ttr_pkg::StRead) begin
      rd_precise_q <= precise_mem[rd_pos_q];
      rd_utc_q     <= utc_mem[rd_pos_q];
    end
  end

endmodule

`default_nettype wire

/* sv/ttr_checker.sv */
`default_nettype none

`include "trigger_timestamp_realigner_macros.svh"

module ttr_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic            out_released_i,
  input wire logic            out_flag_i,
  input wire ttr_pkg::stamp_t out_stamp_i
);

  // a pending result is not withdrawn
  `TTR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // a flagged result is always a released trigger
  `TTR_ASSERT_SAME(a_flag_released, out_valid_i && out_flag_i, out_released_i)

  // held triggers and add results carry no stamp
  `TTR_ASSERT_SAME(a_held_no_stamp, out_valid_i && !out_released_i, out_stamp_i == '0)

  // every accepted beat leaves a result pending or the block busy
  `TTR_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_i, out_valid_i || !in_ready_i)

endmodule

bind trigger_timestamp_realigner ttr_checker u_ttr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_released_i(out_o.released),
  .out_flag_i    (out_o.no_match_flag),
  .out_stamp_i   (out_o.stamp_out)
);

`default_nettype wire

/* test/tb_trigger_timestamp_realigner.sv */
`timescale 1ns / 100ps

module tb_trigger_timestamp_realigner;

  // ring size of the instance under test, matches the default parameter
  localparam int unsigned RING = ttr_pkg::DefRingDepth;

  // beat kinds on the input channel
  localparam logic KindAdd     = 1'b0;
  localparam logic KindTrigger = 1'b1;

  localparam ttr_pkg::stamp_t    STAMP_MAX = '1;
  localparam ttr_pkg::cfg_word_t CFG_MAX   = '1;

  // receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 300;
  // worst case walk of a full ring plus a few cycles of slack
  localparam int TAIL_CYCLES = 4 * RING + 8;
  // generous ceiling, a clean run needs well under a tenth of this
  localparam int CYCLE_LIMIT = 500_000;

  localparam int PHASES     = 6;
  localparam int PHASE_BEATS = 85;

  typedef struct {
    logic            kind;
    ttr_pkg::stamp_t ev_precise;
    ttr_pkg::stamp_t ev_utc;
    ttr_pkg::stamp_t trig;
    ttr_pkg::stamp_t now;
  } realign_beat_t;

  typedef struct packed {
    logic            released;
    logic            no_match;
    ttr_pkg::stamp_t stamp;
    logic            overflow;
  } realign_result_t;

  // predicts the realigned trigger for every accepted beat and checks the
  // result beats against it in order
  class realign_model;
    ttr_pkg::stamp_t    precise_ring [RING];
    ttr_pkg::stamp_t    utc_ring     [RING];
    int unsigned        wr_ptr;
    int unsigned        rd_ptr;
    int unsigned        fill;
    bit                 waiting;
    ttr_pkg::stamp_t    wait_start;
    ttr_pkg::cfg_word_t tol;
    ttr_pkg::cfg_word_t max_wait;
    realign_result_t    due_results [$];
    int unsigned        errors;

    function ttr_pkg::stamp_t gap_between(ttr_pkg::stamp_t a, ttr_pkg::stamp_t b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void set_reg(ttr_pkg::cfg_idx_t idx, ttr_pkg::cfg_word_t val);
      if (idx == ttr_pkg::CfgMatchTol) tol = val;
      else if (idx == ttr_pkg::CfgMaxWait) max_wait = val;
    endfunction

    function void take_beat(realign_beat_t b);
      realign_result_t r;
      int unsigned     slot;
      r = '0;
      if (b.kind == KindAdd) begin
        precise_ring[wr_ptr] = b.ev_precise;
        utc_ring[wr_ptr]     = b.ev_utc;
        wr_ptr = (wr_ptr + 1) % RING;
        if (fill == RING) begin
          rd_ptr = (rd_ptr + 1) % RING;
          r.overflow = 1'b1;
        end else begin
          fill++;
        end
      end else if (fill == 0) begin
        if (!waiting) begin
          waiting    = 1'b1;
          wait_start = b.now;
        end
        if (gap_between(b.now, wait_start) > {23'd0, max_wait}) begin
          waiting    = 1'b0;
          wait_start = '0;
          r.released = 1'b1;
          r.no_match = 1'b1;
          r.stamp    = b.trig;
        end
      end else begin
        r.released = 1'b1;
        r.stamp    = b.trig;
        while (fill > 0) begin
          slot   = rd_ptr;
          rd_ptr = (rd_ptr + 1) % RING;
          fill--;
          if (gap_between(b.trig, utc_ring[slot]) > {23'd0, tol}) begin
            r.no_match = 1'b1;
          end else begin
            r.stamp = precise_ring[slot];
            break;
          end
        end
        waiting    = 1'b0;
        wait_start = '0;
      end
      due_results = {due_results, r};
    endfunction

    task report(string field, ttr_pkg::stamp_t got_v, ttr_pkg::stamp_t want_v);
      errors++;
      if (errors <= 40)
        $display("tb: mismatch on %s: got %h, expected %h", field, got_v, want_v);
    endtask

    task match_result(logic released, logic no_match, ttr_pkg::stamp_t stamp,
                      logic overflow);
      realign_result_t want;
      if (due_results.size() == 0) begin
        report("unexpected result beat", stamp, '0);
        return;
      end
      want = due_results.pop_front();
      if (released !== want.released)
        report("released", 63'(released), 63'(want.released));
      if (no_match !== want.no_match)
        report("no_match_flag", 63'(no_match), 63'(want.no_match));
      if (stamp !== want.stamp)
        report("stamp_out", stamp, want.stamp);
      if (overflow !== want.overflow)
        report("overflow", 63'(overflow), 63'(want.overflow));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  ttr_pkg::cfg_idx_t  cfg_idx;
  ttr_pkg::cfg_word_t cfg_data;

  ttr_in_if  in_bus ();
  ttr_out_if out_bus ();

  realign_model model = new;

  // shared between the sender and the receiver process
  bit              steady;      // no random idling on either side in this phase
  bit              hold_req;    // asks the receiver for one long hold-off
  bit              offering;    // sender currently has valid high
  int              beats_sent;
  int              cycle_count;
  ttr_pkg::stamp_t center;      // stamp around which events and triggers cluster

  trigger_timestamp_realigner uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog, a hung handshake ends up here
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // every result beat is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      model.match_result(out_bus.released, out_bus.no_match_flag, out_bus.stamp_out,
                         out_bus.overflow);
  end

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  function automatic longint unsigned rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic ttr_pkg::stamp_t rand_stamp();
    longint unsigned v;
    v = rnd64();
    return v[62:0];
  endfunction

  function automatic ttr_pkg::cfg_word_t rand_cfg();
    longint unsigned v;
    v = rnd64();
    return v[39:0];
  endfunction

  // idle length: mostly a short one, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  // step away from a stamp in either direction, wrapping at the stamp width
  function automatic ttr_pkg::stamp_t offset_stamp(ttr_pkg::stamp_t c,
                                                   longint unsigned off);
    return ($urandom_range(0, 1) == 0) ? c + off[62:0] : c - off[62:0];
  endfunction

  // distance of an event from the trigger: inside tolerance (edge included)
  // or outside it (just past the edge, a bit past, or far away)
  function automatic longint unsigned pick_utc_offset(bit hit);
    longint unsigned t;
    t = 64'(model.tol);
    if (hit) begin
      case ($urandom_range(0, 3))
        0:       return 0;
        1:       return t;
        default: return rnd64() % (t + 1);
      endcase
    end
    case ($urandom_range(0, 2))
      0:       return t + 1;
      1:       return t + 1 + 64'($urandom_range(0, 1000));
      default: return rnd64() >> 2;
    endcase
  endfunction

  // elapsed time of a held trigger, clustered around the wait limit
  function automatic longint unsigned pick_wait_delta();
    longint unsigned w;
    w = 64'(model.max_wait);
    case ($urandom_range(0, 4))
      0:       return w;
      1:       return w + 1;
      2:       return rnd64() % (w + 1);
      3:       return w + 1 + 64'($urandom_range(0, 100000));
      default: return rnd64() >> 1;
    endcase
  endfunction

  function automatic ttr_pkg::stamp_t pick_precise();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return STAMP_MAX;
      default: return rand_stamp();
    endcase
  endfunction

  // unused fields of each kind carry junk, the block must ignore them
  function automatic realign_beat_t make_add(ttr_pkg::stamp_t precise,
                                             ttr_pkg::stamp_t utc);
    realign_beat_t b;
    b.kind       = KindAdd;
    b.ev_precise = precise;
    b.ev_utc     = utc;
    b.trig       = rand_stamp();
    b.now        = rand_stamp();
    return b;
  endfunction

  function automatic realign_beat_t make_trigger(ttr_pkg::stamp_t trig,
                                                 ttr_pkg::stamp_t now);
    realign_beat_t b;
    b.kind       = KindTrigger;
    b.ev_precise = rand_stamp();
    b.ev_utc     = rand_stamp();
    b.trig       = trig;
    b.now        = now;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one beat, wait for the accept, then maybe drop valid for a while
  task automatic send_beat(input realign_beat_t b);
    int gap;
    in_bus.valid               <= 1'b1;
    in_bus.kind                <= b.kind;
    in_bus.event_precise_stamp <= b.ev_precise;
    in_bus.event_utc_stamp     <= b.ev_utc;
    in_bus.trigger_stamp       <= b.trig;
    in_bus.now_ns              <= b.now;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    model.take_beat(b);
    beats_sent++;
    gap = (!steady && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    if (offering) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (model.due_results.size() != 0) @(posedge clk_i);
  endtask

  // both registers back to back, write enable stays high across the pair
  task automatic set_regs(input ttr_pkg::cfg_word_t tol, input ttr_pkg::cfg_word_t wait_ns);
    cfg_we   <= 1'b1;
    cfg_idx  <= ttr_pkg::CfgMatchTol;
    cfg_data <= tol;
    @(posedge clk_i);
    model.set_reg(ttr_pkg::CfgMatchTol, tol);
    cfg_idx  <= ttr_pkg::CfgMaxWait;
    cfg_data <= wait_ns;
    @(posedge clk_i);
    model.set_reg(ttr_pkg::CfgMaxWait, wait_ns);
    cfg_we   <= 1'b0;
  endtask

  // mostly a burst of events and a trigger; on an empty ring the trigger is
  // presented up to four times with a later (or earlier) clock till it is out
  task automatic run_sequence();
    realign_beat_t   nb;
    ttr_pkg::stamp_t trig;
    int              n_adds;
    int              tries;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any kind, any contents
      nb.kind       = ($urandom_range(0, 1) == 1);
      nb.ev_precise = rand_stamp();
      nb.ev_utc     = rand_stamp();
      nb.trig       = rand_stamp();
      nb.now        = rand_stamp();
      send_beat(nb);
      return;
    end
    center = center + 63'($urandom_range(0, 65535));
    // short bursts mostly, sometimes enough to wrap the ring
    n_adds = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 4) : $urandom_range(12, 20);
    repeat (n_adds)
      send_beat(make_add(pick_precise(),
                         offset_stamp(center, pick_utc_offset($urandom_range(0, 4) < 2))));
    // a stray trigger now and then, unrelated to the events
    trig = ($urandom_range(0, 6) == 0) ? rand_stamp() : center;
    if (model.fill != 0) begin
      send_beat(make_trigger(trig, rand_stamp()));
    end else begin
      tries = $urandom_range(1, 4);
      repeat (tries) begin
        send_beat(make_trigger(trig, model.waiting ?
                                     offset_stamp(model.wait_start, pick_wait_delta()) :
                                     rand_stamp()));
        if (!model.waiting) break;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long hold-off, the sender keeps offering meanwhile
        hold_req = 1'b0;
        if (stall_left == 0) out_bus.ready <= 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_bus.ready <= 1'b1;
      end else if (rst_ni && !steady && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_bus.ready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    ttr_pkg::cfg_word_t tol;
    ttr_pkg::cfg_word_t wt;
    int                 phase_end;
    bit                 hold_done;
    bit                 pause_done;

    steady     = 1'b0;
    hold_req   = 1'b0;
    offering   = 1'b0;
    beats_sent = 0;
    center     = '0;

    rst_ni                     <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_idx                    <= ttr_pkg::CfgMatchTol;
    cfg_data                   <= '0;
    in_bus.valid               <= 1'b0;
    in_bus.kind                <= KindAdd;
    in_bus.event_precise_stamp <= '0;
    in_bus.event_utc_stamp     <= '0;
    in_bus.trigger_stamp       <= '0;
    in_bus.now_ns              <= '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: tolerance 100, wait limit 1000
    set_regs(40'd100, 40'd1000);

    // empty ring: first hold latches the clock, a later hold right at the
    // limit stays held, then a clock that stepped back past it forces release
    send_beat(make_trigger(63'd123, 63'd5000));
    send_beat(make_trigger(63'd123, 63'd6000));
    send_beat(make_trigger(63'd123, 63'd3999));

    // extreme stamps, exact match and a match right at the tolerance edge
    send_beat(make_add('0, STAMP_MAX));
    send_beat(make_add(STAMP_MAX, '0));
    send_beat(make_trigger(STAMP_MAX, rand_stamp()));
    send_beat(make_trigger(63'd100, rand_stamp()));

    // overfill the ring: the last add drops the oldest entry; the third
    // event sits on the tolerance edge, the sixth just past it
    for (int i = 0; i <= int'(RING); i++) begin
      if (i == 2)
        send_beat(make_add(63'd7777, 63'd50100));
      else if (i == 5)
        send_beat(make_add(63'd8888, 63'd49899));
      else
        send_beat(make_add(rand_stamp(), rand_stamp()));
    end
    // skip one then match, then skip everything left and come out unmatched
    send_beat(make_trigger(63'd50000, rand_stamp()));
    send_beat(make_trigger(63'd50000, rand_stamp()));

    // random part, one register setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          tol = '0;
          wt  = '0;
        end
        1: begin
          tol = CFG_MAX;
          wt  = CFG_MAX;
        end
        2: begin
          tol = 40'($urandom_range(1, 1000));
          wt  = 40'($urandom_range(1, 5000));
        end
        3: begin
          tol = rand_cfg();
          wt  = rand_cfg();
        end
        4: begin
          tol = 40'd1;
          wt  = CFG_MAX;
        end
        default: begin
          tol = CFG_MAX;
          wt  = '0;
        end
      endcase
      set_regs(tol, wt);
      steady = (ph == 2);

      // stamps near zero, near the top of the range, or anywhere
      case ($urandom_range(0, 2))
        0:       center = 63'($urandom_range(0, 5000));
        1:       center = STAMP_MAX - 63'($urandom_range(0, 1 << 20));
        default: center = rand_stamp();
      endcase

      phase_end  = beats_sent + PHASE_BEATS;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      while (beats_sent < phase_end) begin
        if ((ph == 1 || ph == 3) && !hold_done && beats_sent > phase_end - 55) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if ((ph == 2 && !pause_done && beats_sent > phase_end - 40) ||
            $urandom_range(0, 32) == 0) begin
          // sender waits until the block has handed back everything
          drain();
          pause_done = 1'b1;
        end
        run_sequence();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (model.errors == 0 && model.due_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* trigger_timestamp_realigner.f */
+incdir+sv
sv/ttr_pkg.sv
sv/ttr_in_if.sv
sv/ttr_out_if.sv
sv/trigger_timestamp_realigner.sv
sv/ttr_checker.sv
test/tb_trigger_timestamp_realigner.sv
